### sv/mie_pkg.sv
// Package for the modular inverse block: status codes and controller/datapath interface types.
// No dependencies.
package mie_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOINV = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // datapath command, issued by the controller
   typedef struct packed {
      logic load;      // load operand and modulus, reset coefficients (t0 zero, t1 one)
      logic div_init;  // start a shift-subtract division r0 / r1
      logic div_step;  // one quotient bit
      logic mul_init;  // start q * t1m
      logic mul_step;  // one multiplier bit
      logic update;    // apply new remainder and coefficient
      logic finish;    // form the final inverse
   } cmd_type;

   // datapath status, read by the controller
   typedef struct packed {
      logic below;     // operand below modulus
      logic a_zero;
      logic a_one;
      logic div_done;
      logic rem_zero;
      logic mul_done;
      logic gcd_one;
   } stat_type;

endpackage

### sv/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: joins the controller and the datapath.
// Depends on mie_pkg, mie_control, mie_datapath.
//
// Computes operand^-1 mod modulus by the extended Euclidean algorithm.
// Write the modulus through csr_write_enable/csr_write_data while idle.
// Request channel: req_valid/req_stall carry one operand beat; a beat is
// taken when req_valid is high and req_stall low. Response channel:
// rsp_valid/rsp_stall carry rsp_inverse and rsp_status (0 inverted,
// 1 not invertible, 2 operand not below modulus).
// Range and zero cases go from the accepting edge straight to the response;
// operand one first passes the finish step. Otherwise each Euclidean
// iteration that updates the coefficients runs a bit-serial divider, one
// quotient bit a cycle, then a bit-serial shift-add multiplier and an update,
// and the final iteration the divider and finish. The block takes one
// operand at a time; req_stall stays high until the result beat is taken,
// so a new beat is taken no earlier than the cycle after the result leaves.
// While rsp_stall is high the result holds on the ports.
// Reset clears the modulus to zero and returns the controller to idle.
module modular_inverse_ext_euclid #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_inverse,
   output logic [1:0]  rsp_status
);

   logic [31:0]        modulus_ff;
   logic [WIDTH-1:0]   modulus_w, operand_w, inverse_w;
   mie_pkg::cmd_type   cmd;
   mie_pkg::stat_type  stat;
   logic               use_inv;

   // hold the modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data;
      end
   end

   // drop port bits above WIDTH; zero-extend when WIDTH is wider than the port
   always_comb begin
      modulus_w = '0;
      operand_w = '0;
      for (int i = 0; i < WIDTH && i < 32; i++) begin
         modulus_w[i] = modulus_ff[i];
         operand_w[i] = req_operand[i];
      end
   end

   mie_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd), .status(rsp_status), .use_inv(use_inv)
   );

   mie_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd),
      .operand(operand_w), .modulus(modulus_w),
      .stat(stat), .inverse(inverse_w)
   );

   // the inverse is below the modulus, so its upper bits are zero
   always_comb begin
      rsp_inverse = '0;
      for (int i = 0; i < WIDTH && i < 32; i++) begin
         rsp_inverse[i] = use_inv && inverse_w[i];
      end
   end

endmodule

### sv/mie_datapath.sv
// Datapath of the modular inverse block: remainders, quotient divider, coefficient multiplier.
// Depends on mie_pkg.
module mie_datapath #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  mie_pkg::cmd_type    cmd,
   input  logic [WIDTH-1:0]    operand,
   input  logic [WIDTH-1:0]    modulus,
   output mie_pkg::stat_type   stat,
   output logic [WIDTH-1:0]    inverse
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH-1:0] t0m_ff, t0m_in, t1m_ff, t1m_in;
   logic             t0s_ff, t0s_in, t1s_ff, t1s_in;
   logic [WIDTH-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [WIDTH-1:0] p_ff, p_in, mq_ff, mq_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] inv_ff, inv_in;

   logic [WIDTH:0]   rem_sh;
   logic [WIDTH-1:0] nm;
   logic             ns;

   always_comb begin
      rem_sh = {rem_ff, q_ff[WIDTH-1]};
      // t0 - q*t1 in sign-magnitude: add p with sign !t1s
      if (t0s_ff == !t1s_ff) begin
         nm = t0m_ff + p_ff;
         ns = t0s_ff;
      end else if (t0m_ff >= p_ff) begin
         nm = t0m_ff - p_ff;
         ns = t0s_ff;
      end else begin
         nm = p_ff - t0m_ff;
         ns = !t1s_ff;
      end
   end

   always_comb begin
      m_in = m_ff; r0_in = r0_ff; r1_in = r1_ff;
      t0m_in = t0m_ff; t0s_in = t0s_ff; t1m_in = t1m_ff; t1s_in = t1s_ff;
      q_in = q_ff; rem_in = rem_ff; p_in = p_ff; mq_in = mq_ff;
      cnt_in = cnt_ff; inv_in = inv_ff;
      if (cmd.load) begin
         m_in = modulus; r0_in = modulus; r1_in = operand;
         t0m_in = '0; t0s_in = 1'b1;
         t1m_in = {{(WIDTH-1){1'b0}}, 1'b1}; t1s_in = 1'b1;
         inv_in = '0;
      end
      if (cmd.div_init) begin
         q_in = r0_ff; rem_in = '0; cnt_in = CW'(WIDTH);
      end
      if (cmd.div_step) begin
         // restoring division: dividend bits shift out of q, quotient bits in
         if (rem_sh >= {1'b0, r1_ff}) begin
            rem_in = WIDTH'(rem_sh - {1'b0, r1_ff});
            q_in   = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WIDTH-1:0];
            q_in   = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.mul_init) begin
         p_in = '0; mq_in = q_ff; cnt_in = CW'(WIDTH);
      end
      if (cmd.mul_step) begin
         // msb-first shift-add, product kept modulo 2^WIDTH
         p_in  = {p_ff[WIDTH-2:0], 1'b0} + (mq_ff[WIDTH-1] ? t1m_ff : '0);
         mq_in = {mq_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.update) begin
         t0m_in = t1m_ff; t0s_in = t1s_ff;
         t1m_in = nm;     t1s_in = ns;
         r0_in = r1_ff;   r1_in = rem_ff;
      end
      if (cmd.finish) begin
         inv_in = (!t1s_ff && t1m_ff != '0) ? m_ff - t1m_ff : t1m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      m_ff <= m_in; r0_ff <= r0_in; r1_ff <= r1_in;
      t0m_ff <= t0m_in; t0s_ff <= t0s_in; t1m_ff <= t1m_in; t1s_ff <= t1s_in;
      q_ff <= q_in; rem_ff <= rem_in; p_ff <= p_in; mq_ff <= mq_in;
      inv_ff <= inv_in;
   end

   always_comb begin
      stat.below    = operand < modulus;
      stat.a_zero   = operand == '0;
      stat.a_one    = operand == {{(WIDTH-1){1'b0}}, 1'b1};
      stat.div_done = cnt_ff == '0;
      stat.rem_zero = rem_ff == '0;
      stat.mul_done = cnt_ff == '0;
      stat.gcd_one  = r1_ff == {{(WIDTH-1){1'b0}}, 1'b1};
   end

   assign inverse = inv_ff;

endmodule

### sv/mie_control.sv
// Controller of the modular inverse block: sequences division, multiply and update per iteration.
// Depends on mie_pkg.
module mie_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  mie_pkg::stat_type  stat,
   output mie_pkg::cmd_type   cmd,
   output logic [1:0]         status,
   output logic               use_inv
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_INIT, S_DIV, S_MUL, S_UPDATE, S_FINISH, S_RESP
   } state_type;

   state_type   state_ff;
   logic [1:0]  status_ff;
   logic        use_inv_ff;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;
   assign status    = status_ff;
   assign use_inv   = use_inv_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:     cmd.load = accept;
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV:      begin
            cmd.div_step = !stat.div_done;
            cmd.mul_init = stat.div_done;
         end
         S_MUL:      cmd.mul_step = !stat.mul_done;
         S_UPDATE:   cmd.update = 1'b1;
         S_FINISH:   cmd.finish = 1'b1;
         S_RESP:     ;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         status_ff  <= mie_pkg::ST_OK;
         use_inv_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (accept) begin
               use_inv_ff <= 1'b0;
               if (!stat.below) begin
                  status_ff <= mie_pkg::ST_RANGE; state_ff <= S_RESP;
               end else if (stat.a_zero) begin
                  status_ff <= mie_pkg::ST_NOINV; state_ff <= S_RESP;
               end else if (stat.a_one) begin
                  // the loaded coefficient t1 is one: finish straight away
                  status_ff <= mie_pkg::ST_OK; state_ff <= S_FINISH;
               end else begin
                  status_ff <= mie_pkg::ST_OK; state_ff <= S_DIV_INIT;
               end
            end
            S_DIV_INIT: state_ff <= S_DIV;
            S_DIV: if (stat.div_done) begin
               state_ff <= stat.rem_zero ? S_FINISH : S_MUL;
            end
            S_MUL:    if (stat.mul_done) state_ff <= S_UPDATE;
            S_UPDATE: state_ff <= S_DIV_INIT;
            S_FINISH: begin
               if (stat.gcd_one) begin
                  use_inv_ff <= 1'b1;
               end else begin
                  status_ff <= mie_pkg::ST_NOINV;
               end
               state_ff <= S_RESP;
            end
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_use_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && use_inv_ff |-> status_ff == mie_pkg::ST_OK)
      else $error("inverse used with bad status");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.div_init, cmd.div_step, cmd.mul_init,
                  cmd.mul_step, cmd.update, cmd.finish}) <= 1)
      else $error("more than one datapath command");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(status_ff))
      else $error("result dropped under stall");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for modular_inverse_ext_euclid: directed and random operands
// against an in-bench extended Euclid predictor. Depends on mie_pkg and the block.
module tb_top;

   localparam int WIDTH = 32;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [31:0] inverse;
      logic [1:0]  status;
   } inv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_operand = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_inverse;
   logic [1:0]  rsp_status;

   logic [31:0]  modulus_q = '0;       // predictor copy of the register
   logic [31:0]  operand_q[$];         // beats waiting to be offered
   inv_result_type inverse_q[$];       // expected result beats, oldest first
   int           error_count = 0;
   int           cycle_count = 0;
   int           beat_count = 0;
   int           result_count = 0;
   int           hold_off = 0;         // long receiver stall, counted down below
   int           send_gap = 0;
   bit           pause_sender = 1'b0;
   logic [WIDTH-1:0] primes[4] = '{32'd65537, 32'd4294967291, 32'd251, 32'd2147483647};

   modular_inverse_ext_euclid #(.WIDTH(WIDTH)) dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_operand(req_operand),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inverse(rsp_inverse), .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   // Predict one result: range check, zero, one, then the Euclidean loop with
   // the operand coefficient kept as sign and magnitude.
   function automatic inv_result_type predict_inverse(logic [31:0] a, logic [31:0] m);
      inv_result_type res;
      logic [WIDTH-1:0] r0, r1, q, r, t0m, t1m, pm, nm;
      bit t0s, t1s, ns;
      res.inverse = '0;
      if (a >= m) begin
         res.status = mie_pkg::ST_RANGE;
         return res;
      end
      if (a == 0) begin
         res.status = mie_pkg::ST_NOINV;
         return res;
      end
      if (a == 1) begin
         res.inverse = 32'd1;
         res.status = mie_pkg::ST_OK;
         return res;
      end
      r0 = m; r1 = a; t0m = '0; t0s = 1'b1; t1m = 32'd1; t1s = 1'b1;
      forever begin
         q = r0 / r1;
         r = r0 % r1;
         if (r == 0) break;
         pm = q * t1m;
         // t0 - q*t1: the product carries the opposite sign of t1
         if (t0s == !t1s) begin
            nm = t0m + pm; ns = t0s;
         end else if (t0m >= pm) begin
            nm = t0m - pm; ns = t0s;
         end else begin
            nm = pm - t0m; ns = !t1s;
         end
         t0m = t1m; t0s = t1s; t1m = nm; t1s = ns;
         r0 = r1; r1 = r;
      end
      if (r1 != 1) begin
         res.status = mie_pkg::ST_NOINV;
         return res;
      end
      if (!t1s && t1m != 0) t1m = m - t1m;
      res.inverse = t1m;
      res.status = mie_pkg::ST_OK;
      return res;
   endfunction

   function automatic int short_or_long_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   // Driver: advance to the next operand once the current beat is taken; hold
   // the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            inverse_q.push_back(predict_inverse(req_operand, modulus_q));
            beat_count <= beat_count + 1;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (operand_q.size() > 0 && !pause_sender) begin
            req_valid <= 1'b1;
            req_operand <= operand_q.pop_front();
            send_gap <= short_or_long_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation, then pick
   // the stall for the next cycle.
   always @(posedge clock) begin
      inv_result_type exp_res;
      int pick;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (inverse_q.size() == 0) begin
               $error("unexpected result beat inverse=%0h status=%0d",
                      rsp_inverse, rsp_status);
               error_count <= error_count + 1;
            end else begin
               exp_res = inverse_q.pop_front();
               if (rsp_inverse !== exp_res.inverse) begin
                  $error("inverse: expected %0h actual %0h", exp_res.inverse, rsp_inverse);
                  error_count <= error_count + 1;
               end
               if (rsp_status !== exp_res.status) begin
                  $error("status: expected %0d actual %0d", exp_res.status, rsp_status);
                  error_count <= error_count + 1;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            rsp_stall <= (pick < 25) ? 1'b1 : (pick < 27 ? 1'b1 : 1'b0);
            if (pick >= 97) hold_off <= $urandom_range(10, 300);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top: errors");
         $finish;
      end
   end

   // Wait until every expectation is met and the block is quiet.
   task automatic drain();
      while (operand_q.size() > 0 || req_valid || inverse_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_modulus(logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      modulus_q = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Well-formed operands mostly below the modulus, some edge values, some out
   // of range.
   task automatic random_operands(int count, logic [31:0] m);
      logic [31:0] v;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (m == 0 || pick < 8) v = $urandom();
         else if (pick < 14) v = m - $urandom_range(0, 3);
         else if (pick < 18) v = $urandom_range(0, 3);
         else v = $urandom() % m;
         operand_q.push_back(v);
      end
   endtask

   initial begin
      logic [31:0] m;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset modulus is zero: every operand is out of range.
      operand_q.push_back(32'd0);
      operand_q.push_back(32'd5);
      drain();

      write_modulus(32'd4294967291);  // largest 32-bit prime
      operand_q.push_back(32'd0);
      operand_q.push_back(32'd1);
      operand_q.push_back(32'd2);
      operand_q.push_back(32'd4294967290);
      operand_q.push_back(32'd4294967291);
      operand_q.push_back(32'hFFFFFFFF);
      operand_q.push_back(32'h55555555);
      operand_q.push_back(32'hAAAAAAAA);
      write_modulus(32'hFFFFFFFF);      // composite, gcd cases
      operand_q.push_back(32'd3);
      operand_q.push_back(32'd5);
      operand_q.push_back(32'd7);
      operand_q.push_back(32'hFFFFFFFE);
      write_modulus(32'd1);
      operand_q.push_back(32'd0);
      operand_q.push_back(32'd1);
      write_modulus(32'd2);
      operand_q.push_back(32'd1);
      operand_q.push_back(32'd0);
      operand_q.push_back(32'd2);
      write_modulus(32'd100);
      operand_q.push_back(32'd10);
      operand_q.push_back(32'd99);
      operand_q.push_back(32'd37);

      // Sender pause: once the queue is offered, hold off until every
      // expected beat has arrived before going on.
      while (operand_q.size() > 0 || req_valid)
         @(posedge clock);
      pause_sender = 1'b1;
      drain();
      pause_sender = 1'b0;

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 5)
            0: m = primes[$urandom_range(0, 3)];
            1: m = $urandom() | 32'h1;
            2: m = $urandom_range(2, 1000);
            3: m = $urandom();
            default: m = 32'hFFFFFFFF;
         endcase
         write_modulus(m);
         if (phase == 4) hold_off = 600;  // long receiver hold-off
         random_operands(62, m);
      end
      write_modulus(32'd0);
      random_operands(10, 32'd0);
      drain();

      $display("covered %0d operand beats, %0d result beats over 17 modulus settings",
               beat_count, result_count);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule

### modular_inverse_ext_euclid.f
sv/mie_pkg.sv
sv/mie_datapath.sv
sv/mie_control.sv
sv/modular_inverse_ext_euclid.sv
tb/sv/tb_top.sv
